// ===== rtl/core/gha_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the GHASH accumulator: function codes,
// register indexes, block geometry and the input stage item.
// ----------------------------------------------------------------------------
package gha_pkg;

   localparam int BLOCK_BYTES    = 16;
   localparam int BITS_PER_BYTE  = 8;
   localparam int BLOCK_BITS     = BLOCK_BYTES * BITS_PER_BYTE;
   localparam int HALF_BITS      = 64;
   localparam int COUNT_WIDTH    = 61;
   localparam int NBYTES_WIDTH   = 5;
   localparam int CSR_IDX_WIDTH  = 1;

   localparam logic [1:0] FUNC_AAD    = 2'd0;
   localparam logic [1:0] FUNC_TEXT   = 2'd1;
   localparam logic [1:0] FUNC_FINISH = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HASH_KEY_HIGH = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HASH_KEY_LOW  = 1'b1;

   localparam logic [NBYTES_WIDTH-1:0] NBYTES_FULL = NBYTES_WIDTH'(BLOCK_BYTES);

   typedef struct packed {
      logic [1:0]              func;
      logic [BLOCK_BITS-1:0]   block;
      logic [NBYTES_WIDTH-1:0] nbytes;
   } item_type;

endpackage
`default_nettype wire

// ===== rtl/core/gha_gfmul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gha_gfmul
// GF(2^128) multiplier in GCM bit order: carry-less product of the
// bit-reversed operands, then a two-step fold by x^128 = x^7 + x^2 + x + 1.
// ----------------------------------------------------------------------------
module gha_gfmul (
   input  wire logic [gha_pkg::BLOCK_BITS-1:0] x,
   input  wire logic [gha_pkg::BLOCK_BITS-1:0] h,
   output logic      [gha_pkg::BLOCK_BITS-1:0] z
);
   import gha_pkg::*;

   logic [BLOCK_BITS-1:0]   xr;
   logic [BLOCK_BITS-1:0]   hr;
   logic [2*BLOCK_BITS-2:0] prod;
   logic [BLOCK_BITS-2:0]   upper;
   logic [BLOCK_BITS+5:0]   fold1;
   logic [5:0]              spill;
   logic [12:0]             fold2;
   logic [BLOCK_BITS-1:0]   rem;

   always_comb begin
      // bit 127 of the word is the x^0 coefficient
      for (int i = 0; i < BLOCK_BITS; i++) begin
         xr[i] = x[BLOCK_BITS-1-i];
         hr[i] = h[BLOCK_BITS-1-i];
      end
      prod = '0;
      for (int i = 0; i < BLOCK_BITS; i++) begin
         for (int j = 0; j < BLOCK_BITS; j++) begin
            prod[i+j] = prod[i+j] ^ (xr[i] & hr[j]);
         end
      end
      upper = prod[2*BLOCK_BITS-2:BLOCK_BITS];
      fold1 = {7'b0, upper} ^ {6'b0, upper, 1'b0} ^ {5'b0, upper, 2'b0} ^ {upper, 7'b0};
      // bits of the first fold that land at x^128 and above
      spill = fold1[BLOCK_BITS+5:BLOCK_BITS];
      fold2 = {7'b0, spill} ^ {6'b0, spill, 1'b0} ^ {5'b0, spill, 2'b0} ^ {spill, 7'b0};
      rem   = prod[BLOCK_BITS-1:0] ^ fold1[BLOCK_BITS-1:0] ^ {115'b0, fold2};
      for (int i = 0; i < BLOCK_BITS; i++) begin
         z[i] = rem[BLOCK_BITS-1-i];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/ghash_accumulator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ghash_accumulator_top
// GCM GHASH over one message, one 16-byte block per clock unless a finish item stalls.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write hash key H (index 0 upper half, index 1 lower half) while
//            the block is idle; no read-back.
//   req_*  : one item per block of additional data (func 0) or ciphertext
//            (func 1) with a count of leading valid bytes, or a finish item
//            (func 2). A short block belongs last in its segment.
//   rsp_*  : one item per finish, carrying the 128-bit tag.
// Timing: an item is registered on acceptance and absorbed into the
//   accumulator from the input register through one GF(2^128) multiply, so
//   one item is taken every cycle unless a finish item stalls. The tag is
//   loaded into the output register as the finish item leaves the input register.
// Stall: while the tag waits, data items keep flowing; only a second finish
//   item holds in the input register until the tag is taken.
// Reset: clears the key, accumulator, byte counts and both valid flags.
// ----------------------------------------------------------------------------
module ghash_accumulator_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [gha_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [gha_pkg::HALF_BITS-1:0]     csr_write_data,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_func,
   input  wire logic [gha_pkg::HALF_BITS-1:0]     req_block_high,
   input  wire logic [gha_pkg::HALF_BITS-1:0]     req_block_low,
   input  wire logic [gha_pkg::NBYTES_WIDTH-1:0]  req_valid_bytes,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [gha_pkg::HALF_BITS-1:0]     rsp_tag_high,
   output logic      [gha_pkg::HALF_BITS-1:0]     rsp_tag_low
);
   import gha_pkg::*;

   logic [BLOCK_BITS-1:0]  key_ff;
   logic [BLOCK_BITS-1:0]  key_in;
   logic [BLOCK_BITS-1:0]  acc_ff;
   logic [BLOCK_BITS-1:0]  acc_in;
   logic [COUNT_WIDTH-1:0] aad_count_ff;
   logic [COUNT_WIDTH-1:0] aad_count_in;
   logic [COUNT_WIDTH-1:0] text_count_ff;
   logic [COUNT_WIDTH-1:0] text_count_in;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   item_type               s1_item_ff;
   item_type               s1_item_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [BLOCK_BITS-1:0]  tag_ff;
   logic [BLOCK_BITS-1:0]  tag_in;

   logic                   req_drop;
   logic                   s1_finish;
   logic                   s1_advance;
   logic [BLOCK_BITS-1:0]  byte_mask;
   logic [BLOCK_BITS-1:0]  lengths;
   logic [BLOCK_BITS-1:0]  operand;
   logic [BLOCK_BITS-1:0]  product;

   // key registers
   always_comb begin
      key_in = key_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_HASH_KEY_HIGH: key_in[BLOCK_BITS-1:HALF_BITS] = csr_write_data;
            CSR_HASH_KEY_LOW:  key_in[HALF_BITS-1:0]          = csr_write_data;
            default:           key_in = key_ff;
         endcase
      end
   end

   // input register
   assign req_drop   = (req_func == FUNC_NONE) ||
                       ((req_func != FUNC_FINISH) && (req_valid_bytes == '0));
   assign s1_finish  = (s1_item_ff.func == FUNC_FINISH);
   assign s1_advance = s1_valid_ff && !(s1_finish && rsp_valid_ff && !rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_item_in.func   = req_func;
      s1_item_in.block  = {req_block_high, req_block_low};
      s1_item_in.nbytes = (req_valid_bytes > NBYTES_FULL) ? NBYTES_FULL : req_valid_bytes;
      s1_valid_in       = req_ready ? (req_valid && !req_drop) : s1_valid_ff;
   end

   // absorb stage
   always_comb begin
      for (int b = 0; b < BLOCK_BYTES; b++) begin
         byte_mask[BLOCK_BITS-1-b*BITS_PER_BYTE -: BITS_PER_BYTE] =
            {BITS_PER_BYTE{NBYTES_WIDTH'(b) < s1_item_ff.nbytes}};
      end
      lengths = {aad_count_ff, 3'b000, text_count_ff, 3'b000};
      operand = acc_ff ^ (s1_finish ? lengths : (s1_item_ff.block & byte_mask));
   end

   gha_gfmul u_gfmul (
      .x (operand),
      .h (key_ff),
      .z (product)
   );

   always_comb begin
      acc_in        = acc_ff;
      aad_count_in  = aad_count_ff;
      text_count_in = text_count_ff;
      tag_in        = tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (s1_advance) begin
         case (s1_item_ff.func)
            FUNC_AAD: begin
               acc_in       = product;
               aad_count_in = aad_count_ff + COUNT_WIDTH'(s1_item_ff.nbytes);
            end
            FUNC_TEXT: begin
               acc_in        = product;
               text_count_in = text_count_ff + COUNT_WIDTH'(s1_item_ff.nbytes);
            end
            FUNC_FINISH: begin
               acc_in        = '0;
               aad_count_in  = '0;
               text_count_in = '0;
               tag_in        = product;
               rsp_valid_in  = 1'b1;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         acc_ff        <= '0;
         aad_count_ff  <= '0;
         text_count_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         key_ff        <= key_in;
         acc_ff        <= acc_in;
         aad_count_ff  <= aad_count_in;
         text_count_ff <= text_count_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_item_ff <= s1_item_in;
      end
      tag_ff <= tag_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tag_high = tag_ff[BLOCK_BITS-1:HALF_BITS];
   assign rsp_tag_low  = tag_ff[HALF_BITS-1:0];

`ifndef SYNTHESIS
   a_finish_gives_tag: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_finish |=> rsp_valid_ff)
      else $error("finish item did not load the tag register");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_finish |=> (acc_ff == '0) && (aad_count_ff == '0)
                                  && (text_count_ff == '0))
      else $error("state not cleared after finish");

   a_stall_only_on_tag: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && s1_finish && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a waiting tag");

   a_aad_keeps_text: assert property (@(posedge clock) disable iff (reset)
      s1_advance && (s1_item_ff.func == FUNC_AAD) |=> $stable(text_count_ff))
      else $error("additional data item changed the ciphertext count");

   a_no_tag_without_finish: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(s1_advance && s1_finish))
      else $error("tag raised without a finish item");
`endif

endmodule
`default_nettype wire

// ===== verif/ghash_accumulator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ghash_accumulator_checker
// Watches the key writes and both channels of the GHASH accumulator. It keeps
// its own GF(2^128) accumulator and byte counts, and queues the tag of every
// accepted finish item. Each returned tag is compared against the oldest one.
// ----------------------------------------------------------------------------
module ghash_accumulator_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [gha_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [gha_pkg::HALF_BITS-1:0]     csr_write_data,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic [1:0]                        req_func,
   input  wire logic [gha_pkg::HALF_BITS-1:0]     req_block_high,
   input  wire logic [gha_pkg::HALF_BITS-1:0]     req_block_low,
   input  wire logic [gha_pkg::NBYTES_WIDTH-1:0]  req_valid_bytes,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [gha_pkg::HALF_BITS-1:0]     rsp_tag_high,
   input  wire logic [gha_pkg::HALF_BITS-1:0]     rsp_tag_low,
   output int                                     error_count,
   output int                                     tags_checked,
   output int                                     tags_outstanding
);
   import gha_pkg::*;

   // x^128 + x^7 + x^2 + x + 1 in the reflected bit order of gcm
   localparam logic [BLOCK_BITS-1:0] REDUCTION = {8'hE1, 120'h0};

   logic [BLOCK_BITS-1:0]  hash_key;
   logic [BLOCK_BITS-1:0]  running_hash;
   logic [COUNT_WIDTH-1:0] aad_bytes;
   logic [COUNT_WIDTH-1:0] text_bytes;
   logic [BLOCK_BITS-1:0]  expected_tags[$];

   initial begin
      error_count      = 0;
      tags_checked     = 0;
      tags_outstanding = 0;
   end

   // bit 127 holds the x^0 coefficient
   function automatic logic [BLOCK_BITS-1:0] gf128_mul(input logic [BLOCK_BITS-1:0] x,
                                                       input logic [BLOCK_BITS-1:0] h);
      logic [BLOCK_BITS-1:0] z;
      logic [BLOCK_BITS-1:0] v;
      z = '0;
      v = h;
      for (int i = BLOCK_BITS - 1; i >= 0; i--) begin
         if (x[i]) begin
            z ^= v;
         end
         v = v[0] ? ((v >> 1) ^ REDUCTION) : (v >> 1);
      end
      return z;
   endfunction

   function automatic logic [BLOCK_BITS-1:0] leading_bytes_mask(input int nbytes);
      return {BLOCK_BITS{1'b1}} << (BLOCK_BITS - BITS_PER_BYTE * nbytes);
   endfunction

   always @(posedge clock) begin : monitor
      logic [BLOCK_BITS-1:0] tag_expected;
      int                    nbytes;
      if (reset) begin
         hash_key     = '0;
         running_hash = '0;
         aad_bytes    = '0;
         text_bytes   = '0;
         expected_tags.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_HASH_KEY_HIGH: hash_key[BLOCK_BITS-1:HALF_BITS] = csr_write_data;
               CSR_HASH_KEY_LOW:  hash_key[HALF_BITS-1:0]          = csr_write_data;
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_tags.size() == 0) begin
               $error("tag returned with none pending: %h_%h", rsp_tag_high, rsp_tag_low);
               error_count++;
            end else begin
               tag_expected = expected_tags.pop_front();
               tags_checked++;
               if (rsp_tag_high !== tag_expected[BLOCK_BITS-1:HALF_BITS]) begin
                  $error("tag_high mismatch: expected %h, actual %h",
                         tag_expected[BLOCK_BITS-1:HALF_BITS], rsp_tag_high);
                  error_count++;
               end
               if (rsp_tag_low !== tag_expected[HALF_BITS-1:0]) begin
                  $error("tag_low mismatch: expected %h, actual %h",
                         tag_expected[HALF_BITS-1:0], rsp_tag_low);
                  error_count++;
               end
            end
         end

         if (req_valid && req_ready) begin
            case (req_func)
               FUNC_FINISH: begin
                  // length block: bit counts of both segments, 64 bits each
                  running_hash = gf128_mul(running_hash ^
                                           {aad_bytes, 3'b000, text_bytes, 3'b000},
                                           hash_key);
                  expected_tags.push_back(running_hash);
                  running_hash = '0;
                  aad_bytes    = '0;
                  text_bytes   = '0;
               end
               FUNC_AAD, FUNC_TEXT: begin
                  if (req_valid_bytes != 0) begin
                     nbytes = (req_valid_bytes > NBYTES_FULL) ? BLOCK_BYTES : req_valid_bytes;
                     running_hash = gf128_mul(running_hash ^ ({req_block_high, req_block_low}
                                              & leading_bytes_mask(nbytes)), hash_key);
                     if (req_func == FUNC_AAD) begin
                        aad_bytes += COUNT_WIDTH'(nbytes);
                     end else begin
                        text_bytes += COUNT_WIDTH'(nbytes);
                     end
                  end
               end
               default: ;
            endcase
         end
      end
      tags_outstanding <= expected_tags.size();
   end

endmodule

// ===== verif/tb_ghash_accumulator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ghash_accumulator_top
// Drives key writes and hash messages into the GHASH accumulator: a directed
// run over padding, ignored items and saturation, then random messages under
// several key settings and handshake pacing modes. The checker does the rest.
// ----------------------------------------------------------------------------
module tb_ghash_accumulator_top;
   import gha_pkg::*;

   localparam int STALL_LIMIT     = 5000;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int PHASES          = 8;
   localparam int SETTLE_CYCLES   = 4;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index        = CSR_HASH_KEY_HIGH;
   logic [HALF_BITS-1:0]     csr_write_data   = '0;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_func         = FUNC_AAD;
   logic [HALF_BITS-1:0]     req_block_high   = '0;
   logic [HALF_BITS-1:0]     req_block_low    = '0;
   logic [NBYTES_WIDTH-1:0]  req_valid_bytes  = NBYTES_FULL;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic [HALF_BITS-1:0]     rsp_tag_high;
   logic [HALF_BITS-1:0]     rsp_tag_low;

   int error_count;
   int tags_checked;
   int tags_outstanding;
   int sender_idle_pct  = 0;
   int rsp_stall_pct    = 0;
   int items_hashed     = 0;
   int key_settings     = 0;
   int stall_cycles     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ghash_accumulator_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_block_high   (req_block_high),
      .req_block_low    (req_block_low),
      .req_valid_bytes  (req_valid_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tag_high     (rsp_tag_high),
      .rsp_tag_low      (rsp_tag_low)
   );

   ghash_accumulator_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_block_high   (req_block_high),
      .req_block_low    (req_block_low),
      .req_valid_bytes  (req_valid_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tag_high     (rsp_tag_high),
      .rsp_tag_low      (rsp_tag_low),
      .error_count      (error_count),
      .tags_checked     (tags_checked),
      .tags_outstanding (tags_outstanding)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ends the run when neither channel nor the key port moves for too long
   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL ghash_accumulator_top");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [HALF_BITS-1:0] random_half();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_item(input logic [1:0] func, input logic [HALF_BITS-1:0] high,
                            input logic [HALF_BITS-1:0] low,
                            input logic [NBYTES_WIDTH-1:0] nbytes);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_block_high  <= high;
      req_block_low   <= low;
      req_valid_bytes <= nbytes;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (func == FUNC_FINISH || (func != FUNC_NONE && nbytes != 0)) begin
         items_hashed++;
      end
   endtask

   task automatic wait_for_tags();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tags_outstanding != 0) @(posedge clock);
   endtask

   // both halves every time; the key port only moves while the block is idle
   task automatic write_hash_key(input logic [HALF_BITS-1:0] high,
                                 input logic [HALF_BITS-1:0] low);
      wait_for_tags();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_HASH_KEY_HIGH;
      csr_write_data   <= high;
      @(posedge clock);
      csr_index        <= CSR_HASH_KEY_LOW;
      csr_write_data   <= low;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      key_settings++;
   endtask

   task automatic send_segment(input logic [1:0] func, input int blocks);
      logic [NBYTES_WIDTH-1:0] nbytes;
      for (int i = 0; i < blocks; i++) begin
         nbytes = NBYTES_FULL;
         if (i == blocks - 1 && $urandom_range(1)) begin
            nbytes = NBYTES_WIDTH'($urandom_range(1, BLOCK_BYTES - 1));
         end
         send_item(func, random_half(), random_half(), nbytes);
      end
   endtask

   task automatic send_message();
      send_segment(FUNC_AAD, $urandom_range(0, 3));
      send_segment(FUNC_TEXT, $urandom_range(0, 6));
      // some messages carry a stray or malformed item
      if ($urandom_range(9) == 0) begin
         send_item(2'($urandom_range(3)), random_half(), random_half(),
                   NBYTES_WIDTH'($urandom_range(0, 31)));
      end
      send_item(FUNC_FINISH, random_half(), random_half(),
                NBYTES_WIDTH'($urandom_range(0, 31)));
      if ($urandom_range(7) == 0) begin
         wait_for_tags();
      end
   endtask

   initial begin
      int phase_start;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_hash_key({$urandom, $urandom}, {$urandom, $urandom});
      send_item(FUNC_AAD,    '1, '1, NBYTES_FULL);
      send_item(FUNC_AAD,    '1, '1, 5'd1);
      send_item(FUNC_TEXT,   '0, '0, NBYTES_FULL);
      send_item(FUNC_TEXT,   '1, '1, 5'd15);
      send_item(FUNC_FINISH, '0, '0, NBYTES_FULL);
      // empty message
      send_item(FUNC_FINISH, '0, '0, NBYTES_FULL);
      // zero byte count and the unused code leave everything as it was
      send_item(FUNC_AAD,    '1, '1, 5'd0);
      send_item(FUNC_NONE,   '1, '1, NBYTES_FULL);
      send_item(FUNC_TEXT,   random_half(), random_half(), 5'd31);
      send_item(FUNC_TEXT,   random_half(), random_half(), 5'd17);
      send_item(FUNC_FINISH, '1, '1, 5'd0);
      // short blocks in the middle of a segment
      send_item(FUNC_AAD,    random_half(), random_half(), 5'd8);
      send_item(FUNC_AAD,    random_half(), random_half(), 5'd9);
      send_item(FUNC_AAD,    random_half(), random_half(), NBYTES_FULL);
      send_item(FUNC_TEXT,   '1, '1, 5'd1);
      send_item(FUNC_TEXT,   random_half(), random_half(), 5'd7);
      send_item(FUNC_TEXT,   random_half(), random_half(), NBYTES_FULL);
      send_item(FUNC_FINISH, random_half(), random_half(), 5'd31);

      for (int phase = 0; phase < PHASES; phase++) begin
         sender_idle_pct = 0;
         rsp_stall_pct   = 0;
         case (phase % 4)
            1: sender_idle_pct = 65;
            2: rsp_stall_pct   = 65;
            3: begin
               sender_idle_pct = 6;
               rsp_stall_pct   = 6;
            end
            default: ;
         endcase
         case (phase)
            0:       write_hash_key('1, '1);
            1:       write_hash_key('0, '0);
            // h = 1 in the field
            2:       write_hash_key({1'b1, 63'h0}, '0);
            default: write_hash_key({$urandom, $urandom}, {$urandom, $urandom});
         endcase
         phase_start = items_hashed;
         while (items_hashed - phase_start < ITEMS_PER_PHASE) send_message();
      end

      wait_for_tags();
      repeat (8) @(posedge clock);
      $display("covered %0d hashed items and %0d tags under %0d key settings,", items_hashed,
               tags_checked, key_settings);
      $display("with free flow, sender gaps, receiver stalls and light mixed pacing");
      if (error_count == 0) begin
         $display("PASS ghash_accumulator_top");
      end else begin
         $display("FAIL ghash_accumulator_top");
      end
      $finish;
   end

endmodule

// ===== ghash_accumulator_top.f =====
rtl/core/gha_pkg.sv
rtl/core/gha_gfmul.sv
rtl/core/ghash_accumulator_top.sv
verif/ghash_accumulator_checker.sv
verif/tb_ghash_accumulator_top.sv
